>>> rtl/core/dvrt_pkg.sv
package dvrt_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [8:0] DEPTH_LIMIT = 9'(TABLE_DEPTH);
   localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(TABLE_DEPTH);

   localparam logic [2:0] CMD_SET       = 3'd0;
   localparam logic [2:0] CMD_REMOVE    = 3'd1;
   localparam logic [2:0] CMD_LOOKUP    = 3'd2;
   localparam logic [2:0] CMD_ADVERTISE = 3'd3;
   localparam logic [2:0] CMD_TICK      = 3'd4;
   localparam logic [2:0] CMD_PURGE     = 3'd5;

   localparam logic [1:0] STAT_DONE   = 2'd0;
   localparam logic [1:0] STAT_MISS   = 2'd1;
   localparam logic [1:0] STAT_REJECT = 2'd2;

   localparam logic [7:0] BROADCAST = 8'd255;
   localparam logic [7:0] POISON    = 8'd255;
   localparam logic [7:0] COST_CAP  = 8'd254;
   localparam logic [7:0] NO_HOP    = 8'd255;

   localparam logic [30:0] MAX_AGE_RESET = 31'd30000;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] destination;
      logic [7:0] hop_addr;
      logic [7:0] cost;
      logic [7:0] neighbor;
   } req_type;

   typedef struct packed {
      logic [7:0] hop_out;
      logic [1:0] status;
      logic [8:0] removed_count;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  hop;
      logic [7:0]  cost;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      entry_type        data;
   } entry_wr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_PURGE
   } state_type;

endpackage

>>> rtl/core/dvrt_entry_store.sv
module dvrt_entry_store (
   input  logic                         clock,
   input  dvrt_pkg::entry_wr_type       wr,
   input  logic [dvrt_pkg::IDX_W-1:0]   rd_addr,
   output dvrt_pkg::entry_type          rd_data
);

   dvrt_pkg::entry_type mem [dvrt_pkg::TABLE_DEPTH];
   dvrt_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/distance_vector_route_table_unit.sv
// A taken word passes through ST_EXEC and its result strobe is registered; a purge walks
// every entry in ST_PURGE. No new word is taken during the single read-then-update pass
// through the entry memory; purge walks one entry a cycle through the shared age unit.
// Reset (synchronous, active high) clears every valid bit at once, the tick counter
// and max_age back to 30000; no clearing pass is needed.
// Results cannot be stalled by the receiver: each is shown for one cycle only.
module distance_vector_route_table_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dvrt_pkg::req_type req_data,
   output logic              rsp_strobe,
   output dvrt_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [30:0]       csr_data
);

   dvrt_pkg::state_type state_ff, state_in;

   dvrt_pkg::req_type req_ff;
   logic [dvrt_pkg::TABLE_DEPTH-1:0] valid_ff;
   logic [31:0] time_now_ff;
   logic [30:0] max_age_ff;
   logic [dvrt_pkg::CNT_W-1:0] scan_ff, scan_in;
   logic eval_ff, eval_in;
   logic [dvrt_pkg::IDX_W-1:0] eval_idx_ff, eval_idx_in;
   logic [8:0] count_ff, count_in;
   logic rsp_strobe_ff;
   dvrt_pkg::rsp_type rsp_data_ff;

   logic accept;
   logic valid_we, valid_val;
   logic [dvrt_pkg::IDX_W-1:0] valid_idx;
   logic time_inc;
   logic rsp_fire;
   dvrt_pkg::rsp_type rsp_next;
   dvrt_pkg::entry_wr_type wr;
   logic [dvrt_pkg::IDX_W-1:0] rd_addr;
   dvrt_pkg::entry_type rd_data;

   logic [dvrt_pkg::IDX_W-1:0] req_idx;
   logic in_range;
   logic [7:0] new_cost;
   logic [31:0] age;
   logic stale;

   assign accept    = start && !busy;
   assign busy      = (state_ff != dvrt_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign req_idx  = req_ff.destination[dvrt_pkg::IDX_W-1:0];
   assign in_range = ({1'b0, req_ff.destination} < dvrt_pkg::DEPTH_LIMIT);
   assign new_cost = (req_ff.cost >= dvrt_pkg::COST_CAP) ? dvrt_pkg::COST_CAP
                                                        : req_ff.cost + 8'd1;

   // The age unit, shared by every entry of a purge walk.
   assign age   = time_now_ff - rd_data.stamp;
   assign stale = age > {1'b0, max_age_ff};

   // During a walk the memory is read one entry ahead of the evaluation.
   assign rd_addr = (state_ff == dvrt_pkg::ST_PURGE) ? scan_ff[dvrt_pkg::IDX_W-1:0]
                                                    : req_data.destination[dvrt_pkg::IDX_W-1:0];

   dvrt_entry_store u_store (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dvrt_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_data.command == dvrt_pkg::CMD_PURGE) ? dvrt_pkg::ST_PURGE
                                                                   : dvrt_pkg::ST_EXEC;
            end
         end
         dvrt_pkg::ST_EXEC: begin
            state_in = dvrt_pkg::ST_IDLE;
         end
         dvrt_pkg::ST_PURGE: begin
            if (scan_ff == dvrt_pkg::SCAN_END) begin
               state_in = dvrt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dvrt_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      wr          = '0;
      valid_we    = 1'b0;
      valid_val   = 1'b0;
      valid_idx   = req_idx;
      time_inc    = 1'b0;
      rsp_fire    = 1'b0;
      rsp_next    = '0;
      scan_in     = scan_ff;
      eval_in     = 1'b0;
      eval_idx_in = eval_idx_ff;
      count_in    = count_ff;

      unique case (state_ff)
         dvrt_pkg::ST_IDLE: begin
            scan_in  = '0;
            count_in = '0;
         end
         dvrt_pkg::ST_EXEC: begin
            rsp_fire = 1'b1;
            wr.addr  = req_idx;
            unique case (req_ff.command)
               dvrt_pkg::CMD_SET: begin
                  if (in_range) begin
                     wr.en     = 1'b1;
                     wr.data   = '{hop: req_ff.hop_addr, cost: req_ff.cost,
                                   stamp: time_now_ff};
                     valid_we  = 1'b1;
                     valid_val = 1'b1;
                  end else begin
                     rsp_next.status = dvrt_pkg::STAT_REJECT;
                  end
               end
               dvrt_pkg::CMD_REMOVE: begin
                  if (in_range && valid_ff[req_idx]) begin
                     valid_we = 1'b1;
                  end else begin
                     rsp_next.status = dvrt_pkg::STAT_MISS;
                  end
               end
               dvrt_pkg::CMD_LOOKUP: begin
                  rsp_next.hop_out = dvrt_pkg::NO_HOP;
                  if (req_ff.destination == dvrt_pkg::BROADCAST) begin
                     rsp_next.status = dvrt_pkg::STAT_REJECT;
                  end else if (in_range && valid_ff[req_idx]) begin
                     rsp_next.hop_out = rd_data.hop;
                  end else begin
                     rsp_next.status = dvrt_pkg::STAT_MISS;
                  end
               end
               dvrt_pkg::CMD_ADVERTISE: begin
                  if (!in_range) begin
                     rsp_next.status = dvrt_pkg::STAT_REJECT;
                  end else if (req_ff.cost == dvrt_pkg::POISON) begin
                     rsp_next.status = dvrt_pkg::STAT_MISS;
                  end else if (!valid_ff[req_idx] || new_cost <= rd_data.cost) begin
                     wr.en     = 1'b1;
                     wr.data   = '{hop: req_ff.neighbor, cost: new_cost,
                                   stamp: time_now_ff};
                     valid_we  = 1'b1;
                     valid_val = 1'b1;
                  end else begin
                     rsp_next.status = dvrt_pkg::STAT_MISS;
                  end
               end
               dvrt_pkg::CMD_TICK: begin
                  time_inc = 1'b1;
               end
               default: begin
                  rsp_next.status = dvrt_pkg::STAT_REJECT;
               end
            endcase
         end
         dvrt_pkg::ST_PURGE: begin
            if (scan_ff != dvrt_pkg::SCAN_END) begin
               scan_in     = scan_ff + dvrt_pkg::CNT_W'(1);
               eval_in     = 1'b1;
               eval_idx_in = scan_ff[dvrt_pkg::IDX_W-1:0];
            end
            valid_idx = eval_idx_ff;
            if (eval_ff && valid_ff[eval_idx_ff] && rd_data.cost != 8'd0 && stale) begin
               valid_we = 1'b1;
               count_in = count_ff + 9'd1;
            end
            if (scan_ff == dvrt_pkg::SCAN_END) begin
               rsp_fire               = 1'b1;
               rsp_next.removed_count = count_in;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dvrt_pkg::ST_IDLE;
         valid_ff      <= '0;
         time_now_ff   <= '0;
         max_age_ff    <= dvrt_pkg::MAX_AGE_RESET;
         eval_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         eval_ff       <= eval_in;
         rsp_strobe_ff <= rsp_fire;
         if (valid_we) begin
            valid_ff[valid_idx] <= valid_val;
         end
         if (time_inc) begin
            time_now_ff <= time_now_ff + 32'd1;
         end
         if (csr_valid && csr_ready) begin
            max_age_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_data;
      end
      scan_ff     <= scan_in;
      eval_idx_ff <= eval_idx_in;
      count_ff    <= count_in;
      if (rsp_fire) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

>>> rtl/core/dvrt_checker.sv
module dvrt_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input dvrt_pkg::req_type req_data,
   input logic              rsp_strobe,
   input dvrt_pkg::rsp_type rsp_data
);

   // A taken word always keeps the unit busy for the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("unit not busy after a word was taken");

   // Every command other than purge answers once it has passed through ST_EXEC and the strobe register.
   a_short_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_data.command != dvrt_pkg::CMD_PURGE |=> ##1 rsp_strobe)
      else $error("result missing two cycles after a word was taken");

   // A result is only shown once the unit has gone idle, and never twice in a row.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy ##1 !rsp_strobe)
      else $error("result strobe while busy or repeated");

   // Only a purge reports removals, and it never carries a hop or a failure.
   a_purge_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.removed_count != 9'd0
         |-> rsp_data.hop_out == 8'd0 && rsp_data.status == dvrt_pkg::STAT_DONE)
      else $error("removal count on a result that is not a purge");

endmodule

bind distance_vector_route_table_unit dvrt_checker u_dvrt_checker (.*);
